// File: rtl/fzp_pkg.sv
// ----------------------------------------------------------------------------
// fzp_pkg
// Widths, register codes and shared types of the fit/zoom/pan coordinate mapper.
// ----------------------------------------------------------------------------
package fzp_pkg;

  localparam int SIZE_W     = 13;
  localparam int ZOOM_W     = 16;
  localparam int ZOOM_FRAC  = 8;
  localparam int PAN_W      = 14;
  localparam int COORD_W    = 15;
  localparam int OUT_W      = 23;

  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = 16;

  // drawn size bound: window size times the largest zoom
  localparam int DRAW_W  = SIZE_W + ZOOM_W - ZOOM_FRAC;
  localparam int OFS_W   = DRAW_W + 2;
  localparam int LOC_W   = OFS_W + 1;
  // dividend bound: |coord| * draw, or local * image size
  localparam int PROD_W  = DRAW_W + COORD_W - 1;
  localparam int SUM_W   = PROD_W + 2;
  localparam int ACC_W   = 2 * SIZE_W + ZOOM_W;

  localparam int ZOOM_ONE  = 1 << ZOOM_FRAC;
  localparam int ZOOM_HALF = 1 << (ZOOM_FRAC - 1);
  localparam int OUT_MAX   = (1 << (OUT_W - 1)) - 1;
  localparam int OUT_MIN   = -(1 << (OUT_W - 1));

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_IMAGE_W  = 3'd0,
    REG_IMAGE_H  = 3'd1,
    REG_WINDOW_W = 3'd2,
    REG_WINDOW_H = 3'd3,
    REG_ZOOM     = 3'd4,
    REG_PAN_H    = 3'd5,
    REG_PAN_V    = 3'd6
  } reg_idx_t;

  localparam logic CMD_TO_IMAGE  = 1'b0;
  localparam logic CMD_TO_SCREEN = 1'b1;

  typedef struct packed {
    logic                     ok;
    logic [SIZE_W-1:0]        iw;
    logic [SIZE_W-1:0]        ih;
    logic [DRAW_W-1:0]        dw;
    logic [DRAW_W-1:0]        dh;
    logic signed [OFS_W-1:0]  ox;
    logic signed [OFS_W-1:0]  oy;
  } geom_t;

  // one axis of a restoring division in flight
  typedef struct packed {
    logic [DRAW_W-1:0] rem;
    logic [PROD_W-1:0] dq;   // dividend bits still to go, quotient bits shifted in
    logic [DRAW_W-1:0] div;
  } lane_t;

  typedef struct packed {
    logic  cmd;
    logic  neg_x;
    logic  over_x;
    logic  neg_y;
    logic  over_y;
    lane_t x;
    lane_t y;
  } slot_t;

endpackage

// File: rtl/fzp_ifs.sv
// ----------------------------------------------------------------------------
// fzp_in_if / fzp_out_if
// Valid/ready channels for coordinate requests and mapped results.
// ----------------------------------------------------------------------------
interface fzp_in_if;
  logic                                valid;
  logic                                ready;
  logic                                command;
  logic signed [fzp_pkg::COORD_W-1:0]  coord_x;
  logic signed [fzp_pkg::COORD_W-1:0]  coord_y;

  modport source (output valid, command, coord_x, coord_y, input ready);
  modport sink   (input valid, command, coord_x, coord_y, output ready);
endinterface

interface fzp_out_if;
  logic                              valid;
  logic                              ready;
  logic signed [fzp_pkg::OUT_W-1:0]  result_x;
  logic signed [fzp_pkg::OUT_W-1:0]  result_y;
  logic                              inside_view;
  logic                              geometry_ok;

  modport source (output valid, result_x, result_y, inside_view, geometry_ok, input ready);
  modport sink   (input valid, result_x, result_y, inside_view, geometry_ok, output ready);
endinterface

// File: rtl/fzp_geometry.sv
// ----------------------------------------------------------------------------
// fzp_geometry
// Configuration registers and the sequencer that derives the drawn rectangle.
// ----------------------------------------------------------------------------
module fzp_geometry (
  input  logic                              clk,
  input  logic                              rst,
  input  logic                              cfg_we,
  input  logic [fzp_pkg::CFG_IDX_W-1:0]     cfg_index,
  input  logic [fzp_pkg::CFG_DATA_W-1:0]    cfg_data,
  output fzp_pkg::geom_t                    geom,
  output logic                              busy
);
  import fzp_pkg::*;

  localparam int CNT_W = $clog2(ACC_W);

  typedef enum logic [2:0] {
    G_IDLE, G_CMP, G_MUL, G_ZMUL, G_DIV, G_ROUND, G_OFS
  } gstate_t;

  gstate_t state;

  logic [SIZE_W-1:0]       image_w, image_h, window_w, window_h;
  logic [ZOOM_W-1:0]       zoom;
  logic signed [PAN_W-1:0] pan_h, pan_v;

  logic [2*SIZE_W-1:0]     prod_h, prod_w, mul_w, mul_h;
  logic [SIZE_W-1:0]       den;
  logic [ACC_W-1:0]        acc_w, acc_h;
  logic [SIZE_W-1:0]       rem_w, rem_h;
  logic [CNT_W-1:0]        cnt;
  logic [DRAW_W-1:0]       draw_w, draw_h;
  logic signed [OFS_W-1:0] ofs_x, ofs_y;
  logic                    ok;

  logic                    use_h;
  logic [SIZE_W-1:0]       num, den_sel;
  logic [ZOOM_W-1:0]       zoom_eff;
  logic [SIZE_W:0]         t_w, t_h;
  logic                    ge_w, ge_h;
  logic [ACC_W-1:0]        rnd_w, rnd_h, sh_w, sh_h;
  logic signed [OFS_W-1:0] dif_w, dif_h, half_w, half_h;

  always_comb begin
    use_h    = prod_h < prod_w;
    num      = use_h ? window_h : window_w;
    den_sel  = use_h ? image_h : image_w;
    zoom_eff = (zoom == '0) ? ZOOM_W'(ZOOM_ONE) : zoom;

    t_w  = {rem_w, acc_w[ACC_W-1]};
    t_h  = {rem_h, acc_h[ACC_W-1]};
    ge_w = t_w >= {1'b0, den};
    ge_h = t_h >= {1'b0, den};

    // round half up: floor(q / 2^F + 1/2)
    rnd_w = acc_w + ACC_W'(ZOOM_HALF);
    rnd_h = acc_h + ACC_W'(ZOOM_HALF);
    sh_w  = rnd_w >> ZOOM_FRAC;
    sh_h  = rnd_h >> ZOOM_FRAC;

    dif_w  = $signed(OFS_W'(window_w)) - $signed(OFS_W'(draw_w));
    dif_h  = $signed(OFS_W'(window_h)) - $signed(OFS_W'(draw_h));
    // halve toward zero
    half_w = (dif_w + $signed(OFS_W'(dif_w[OFS_W-1]))) >>> 1;
    half_h = (dif_h + $signed(OFS_W'(dif_h[OFS_W-1]))) >>> 1;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      image_w  <= '0;
      image_h  <= '0;
      window_w <= '0;
      window_h <= '0;
      zoom     <= ZOOM_W'(ZOOM_ONE);
      pan_h    <= '0;
      pan_v    <= '0;
      ok       <= 1'b0;
      state    <= G_IDLE;
    end else if (cfg_we) begin
      case (reg_idx_t'(cfg_index))
        REG_IMAGE_W:  image_w  <= cfg_data[SIZE_W-1:0];
        REG_IMAGE_H:  image_h  <= cfg_data[SIZE_W-1:0];
        REG_WINDOW_W: window_w <= cfg_data[SIZE_W-1:0];
        REG_WINDOW_H: window_h <= cfg_data[SIZE_W-1:0];
        REG_ZOOM:     zoom     <= cfg_data[ZOOM_W-1:0];
        REG_PAN_H:    pan_h    <= $signed(cfg_data[PAN_W-1:0]);
        REG_PAN_V:    pan_v    <= $signed(cfg_data[PAN_W-1:0]);
        default: ;
      endcase
      state <= G_CMP;
    end else begin
      case (state)
        G_IDLE: ;
        G_CMP: begin
          prod_h <= window_h * image_w;
          prod_w <= window_w * image_h;
          state  <= G_MUL;
        end
        G_MUL: begin
          mul_w <= image_w * num;
          mul_h <= image_h * num;
          den   <= den_sel;
          state <= G_ZMUL;
        end
        G_ZMUL: begin
          acc_w <= mul_w * zoom_eff;
          acc_h <= mul_h * zoom_eff;
          rem_w <= '0;
          rem_h <= '0;
          cnt   <= '0;
          state <= G_DIV;
        end
        G_DIV: begin
          rem_w <= ge_w ? SIZE_W'(t_w - {1'b0, den}) : t_w[SIZE_W-1:0];
          rem_h <= ge_h ? SIZE_W'(t_h - {1'b0, den}) : t_h[SIZE_W-1:0];
          acc_w <= {acc_w[ACC_W-2:0], ge_w};
          acc_h <= {acc_h[ACC_W-2:0], ge_h};
          cnt   <= cnt + 1'b1;
          if (cnt == CNT_W'(ACC_W - 1)) state <= G_ROUND;
        end
        G_ROUND: begin
          draw_w <= (sh_w == '0) ? DRAW_W'(1) : sh_w[DRAW_W-1:0];
          draw_h <= (sh_h == '0) ? DRAW_W'(1) : sh_h[DRAW_W-1:0];
          state  <= G_OFS;
        end
        G_OFS: begin
          ofs_x <= half_w + OFS_W'(pan_h);
          ofs_y <= half_h + OFS_W'(pan_v);
          ok    <= (image_w != '0) && (image_h != '0) &&
                   (window_w != '0) && (window_h != '0);
          state <= G_IDLE;
        end
        default: state <= G_IDLE;
      endcase
    end
  end

  assign busy    = state != G_IDLE;
  assign geom.ok = ok;
  assign geom.iw = image_w;
  assign geom.ih = image_h;
  assign geom.dw = draw_w;
  assign geom.dh = draw_h;
  assign geom.ox = ofs_x;
  assign geom.oy = ofs_y;

endmodule

// File: rtl/fzp_div_cell.sv
// ----------------------------------------------------------------------------
// fzp_div_cell
// One restoring-division cell: one quotient bit per axis, then hand-off.
// ----------------------------------------------------------------------------
module fzp_div_cell (
  input  logic            clk,
  input  logic            rst,
  input  logic            in_valid,
  input  fzp_pkg::slot_t  in_slot,
  output logic            in_ready,
  output logic            out_valid,
  output fzp_pkg::slot_t  out_slot,
  input  logic            out_ready
);
  import fzp_pkg::*;

  function automatic lane_t step(input lane_t l);
    logic [DRAW_W:0] t;
    logic            ge;
    lane_t           r;
    t     = {l.rem, l.dq[PROD_W-1]};
    ge    = t >= {1'b0, l.div};
    r.rem = ge ? DRAW_W'(t - {1'b0, l.div}) : t[DRAW_W-1:0];
    r.dq  = {l.dq[PROD_W-2:0], ge};
    r.div = l.div;
    return r;
  endfunction

  slot_t nxt;

  always_comb begin
    nxt   = in_slot;
    nxt.x = step(in_slot.x);
    nxt.y = step(in_slot.y);
  end

  assign in_ready = !out_valid || out_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (in_ready) begin
      out_valid <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      out_slot <= nxt;
    end
  end

endmodule

// File: rtl/fit_zoom_pan_coord_mapper.sv
// ----------------------------------------------------------------------------
// fit_zoom_pan_coord_mapper
// Maps screen points to image pixels and image coordinates to screen points.
// ----------------------------------------------------------------------------
// Usage:
//   coord_in carries one request item (command, coord_x, coord_y); coord_out
//   returns one result item per request, in order. Both are valid/ready.
//   Command 0 maps a screen point to a clamped image pixel with an inside
//   flag, command 1 maps an image coordinate to a screen point.
//   Configuration is written through cfg_we/cfg_index/cfg_data. Each write
//   starts a rectangle recompute (fit compare, two multiplies, a 42-step
//   bit-serial divide, rounding, centering), during which coord_in.ready
//   is low.
//   Throughput: one item per cycle while coord_out is ready and no register
//   write or recompute is under way. Items pass the operand and product
//   stages, 35 division cells (one quotient bit per cell) and the result
//   stage. Reset clears the configuration registers to their defaults (zoom
//   1.0, sizes zero, so geometry_ok reads 0) and empties the pipeline.
//   When coord_out stalls, items close up behind the held result; ready on
//   coord_in falls only once every stage is full.
// ----------------------------------------------------------------------------
module fit_zoom_pan_coord_mapper (
  input  logic                            clk,
  input  logic                            rst,
  input  logic                            cfg_we,
  input  logic [fzp_pkg::CFG_IDX_W-1:0]   cfg_index,
  input  logic [fzp_pkg::CFG_DATA_W-1:0]  cfg_data,
  fzp_in_if.sink                          coord_in,
  fzp_out_if.source                       coord_out
);
  import fzp_pkg::*;

  localparam int N = PROD_W;

  geom_t geom;
  logic  geo_busy;

  fzp_geometry u_geometry (
    .clk       (clk),
    .rst       (rst),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .geom      (geom),
    .busy      (geo_busy)
  );

  // ---------------- input register
  logic                      v0, rdy0;
  logic                      cmd0;
  logic signed [COORD_W-1:0] cx0, cy0;

  // ---------------- operand stage
  logic                      va, rdya;
  logic                      cmda, negxa, overxa, negya, overya;
  logic [DRAW_W-1:0]         opax, opbx, divx, opay, opby, divy;

  // ---------------- product stage (chain entry)
  logic                      vb, rdyb;
  slot_t                     slotb;

  logic [N:0]                cv, crdy;
  slot_t                     cs [N+1];

  logic                      vo, rdyo;
  logic signed [OUT_W-1:0]   rx, ry;
  logic                      in_view, okr;

  assign coord_in.ready = rdy0 && !geo_busy && !cfg_we;
  assign rdy0 = !v0 || rdya;
  assign rdya = !va || rdyb;
  assign rdyb = !vb || crdy[0];
  assign rdyo = !vo || coord_out.ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      v0 <= 1'b0;
    end else if (rdy0) begin
      v0 <= coord_in.valid && coord_in.ready;
    end
  end

  always_ff @(posedge clk) begin
    if (coord_in.valid && coord_in.ready) begin
      cmd0 <= coord_in.command;
      cx0  <= coord_in.coord_x;
      cy0  <= coord_in.coord_y;
    end
  end

  // local position relative to the drawn rectangle, magnitudes for the
  // reverse mapping
  logic signed [LOC_W-1:0] lx, ly;
  logic                    nlx, nly, olx, oly;
  logic [COORD_W-1:0]      ax, ay;

  always_comb begin
    lx  = $signed(LOC_W'(cx0)) - $signed(LOC_W'(geom.ox));
    ly  = $signed(LOC_W'(cy0)) - $signed(LOC_W'(geom.oy));
    nlx = lx[LOC_W-1];
    nly = ly[LOC_W-1];
    olx = !nlx && ($unsigned(lx) >= LOC_W'(geom.dw));
    oly = !nly && ($unsigned(ly) >= LOC_W'(geom.dh));
    ax  = cx0[COORD_W-1] ? COORD_W'(-cx0) : cx0;
    ay  = cy0[COORD_W-1] ? COORD_W'(-cy0) : cy0;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      va <= 1'b0;
    end else if (rdya) begin
      va <= v0;
    end
  end

  always_ff @(posedge clk) begin
    if (v0 && rdya) begin
      cmda <= cmd0;
      if (cmd0 == CMD_TO_IMAGE) begin
        negxa  <= nlx;
        overxa <= olx;
        negya  <= nly;
        overya <= oly;
        opax   <= (nlx || olx) ? '0 : lx[DRAW_W-1:0];
        opay   <= (nly || oly) ? '0 : ly[DRAW_W-1:0];
        opbx   <= DRAW_W'(geom.iw);
        opby   <= DRAW_W'(geom.ih);
        divx   <= geom.dw;
        divy   <= geom.dh;
      end else begin
        negxa  <= cx0[COORD_W-1];
        overxa <= 1'b0;
        negya  <= cy0[COORD_W-1];
        overya <= 1'b0;
        opax   <= DRAW_W'(ax);
        opay   <= DRAW_W'(ay);
        opbx   <= geom.dw;
        opby   <= geom.dh;
        divx   <= DRAW_W'(geom.iw);
        divy   <= DRAW_W'(geom.ih);
      end
    end
  end

  logic [2*DRAW_W-1:0] px, py;

  always_comb begin
    px = opax * opbx;
    py = opay * opby;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      vb <= 1'b0;
    end else if (rdyb) begin
      vb <= va;
    end
  end

  always_ff @(posedge clk) begin
    if (va && rdyb) begin
      slotb.cmd    <= cmda;
      slotb.neg_x  <= negxa;
      slotb.over_x <= overxa;
      slotb.neg_y  <= negya;
      slotb.over_y <= overya;
      slotb.x.rem  <= '0;
      slotb.x.dq   <= px[PROD_W-1:0];
      slotb.x.div  <= divx;
      slotb.y.rem  <= '0;
      slotb.y.dq   <= py[PROD_W-1:0];
      slotb.y.div  <= divy;
    end
  end

  // ---------------- row of division cells
  assign cv[0]   = vb;
  assign cs[0]   = slotb;
  assign crdy[N] = rdyo;

  for (genvar i = 0; i < N; i++) begin : g_cell
    fzp_div_cell u_cell (
      .clk       (clk),
      .rst       (rst),
      .in_valid  (cv[i]),
      .in_slot   (cs[i]),
      .in_ready  (crdy[i]),
      .out_valid (cv[i+1]),
      .out_slot  (cs[i+1]),
      .out_ready (crdy[i+1])
    );
  end

  // ---------------- result stage
  function automatic logic [OUT_W-1:0] map_out(
    input logic                    cmd,
    input logic                    neg,
    input logic                    over,
    input logic [PROD_W-1:0]       q,
    input logic [SIZE_W-1:0]       isz,
    input logic signed [OFS_W-1:0] ofs
  );
    logic signed [SUM_W-1:0] sum;
    logic [OUT_W-1:0]        r;
    sum = neg ? ($signed(SUM_W'(ofs)) - $signed({2'b00, q}))
              : ($signed(SUM_W'(ofs)) + $signed({2'b00, q}));
    if (cmd == CMD_TO_IMAGE) begin
      if (neg)       r = '0;
      else if (over) r = OUT_W'(isz - 1'b1);
      else           r = q[OUT_W-1:0];
    end else begin
      if (sum > $signed(SUM_W'(OUT_MAX)))      r = OUT_W'(OUT_MAX);
      else if (sum < $signed(SUM_W'(OUT_MIN))) r = OUT_W'(OUT_MIN);
      else                                      r = sum[OUT_W-1:0];
    end
    return r;
  endfunction

  slot_t so;
  assign so = cs[N];

  always_ff @(posedge clk) begin
    if (rst) begin
      vo <= 1'b0;
    end else if (rdyo) begin
      vo <= cv[N];
    end
  end

  always_ff @(posedge clk) begin
    if (cv[N] && rdyo) begin
      okr <= geom.ok;
      if (geom.ok) begin
        rx      <= map_out(so.cmd, so.neg_x, so.over_x, so.x.dq, geom.iw, geom.ox);
        ry      <= map_out(so.cmd, so.neg_y, so.over_y, so.y.dq, geom.ih, geom.oy);
        in_view <= (so.cmd == CMD_TO_IMAGE) && !so.neg_x && !so.over_x &&
                   !so.neg_y && !so.over_y;
      end else begin
        rx      <= '0;
        ry      <= '0;
        in_view <= 1'b0;
      end
    end
  end

  assign coord_out.valid       = vo;
  assign coord_out.result_x    = rx;
  assign coord_out.result_y    = ry;
  assign coord_out.inside_view = in_view;
  assign coord_out.geometry_ok = okr;

endmodule

// File: bench/tb_fit_zoom_pan_coord_mapper.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_fit_zoom_pan_coord_mapper
// Checks the coordinate mapper against an in-bench model of the fit, zoom and
// pan geometry, item by item, over a series of register settings including
// zero sizes, extreme zoom and extreme pan, with random stalls on both sides.
// ----------------------------------------------------------------------------
module tb_fit_zoom_pan_coord_mapper;
  import fzp_pkg::*;

  typedef struct {
    logic                       cmd;
    logic signed [COORD_W-1:0]  x;
    logic signed [COORD_W-1:0]  y;
  } coord_req_t;

  typedef struct {
    logic signed [OUT_W-1:0]  rx;
    logic signed [OUT_W-1:0]  ry;
    logic                     in_view;
    logic                     ok;
  } mapped_t;

  typedef struct {
    longint dw;
    longint dh;
    longint ox;
    longint oy;
  } rect_t;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic                  cfg_we = 1'b0;
  logic [CFG_IDX_W-1:0]  cfg_index = REG_IMAGE_W;
  logic [CFG_DATA_W-1:0] cfg_data = '0;

  fzp_in_if  coord_in ();
  fzp_out_if coord_out ();

  fit_zoom_pan_coord_mapper DUT (
    .clk       (clk),
    .rst       (rst),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .coord_in  (coord_in.sink),
    .coord_out (coord_out.source)
  );

  always #1 clk = ~clk;

  // shadow of the register file
  longint img_w = 0, img_h = 0, win_w = 0, win_h = 0, zoom = ZOOM_ONE;
  longint pan_h = 0, pan_v = 0;

  coord_req_t pending_items[$];
  mapped_t    expected_maps[$];
  int errors = 0;
  int n_sent = 0;
  int n_checked = 0;
  bit calm = 1'b0;
  bit press_req = 1'b0;

  function automatic rect_t fit_rect();
    rect_t  r;
    longint num, den, z;
    if (win_h * img_w < win_w * img_h) begin
      num = win_h; den = img_h;
    end else begin
      num = win_w; den = img_w;
    end
    z = (zoom != 0) ? zoom : ZOOM_ONE;
    r.dw = (2 * img_w * num * z + den * ZOOM_ONE) / (2 * den * ZOOM_ONE);
    r.dh = (2 * img_h * num * z + den * ZOOM_ONE) / (2 * den * ZOOM_ONE);
    if (r.dw < 1) r.dw = 1;
    if (r.dh < 1) r.dh = 1;
    r.ox = (win_w - r.dw) / 2 + pan_h;
    r.oy = (win_h - r.dh) / 2 + pan_v;
    return r;
  endfunction

  function automatic longint clip(longint v, longint lo, longint hi);
    return (v < lo) ? lo : (v > hi) ? hi : v;
  endfunction

  function automatic mapped_t map_point(coord_req_t q);
    mapped_t m;
    rect_t   r;
    longint  lx, ly, rx, ry;
    m = '{rx: '0, ry: '0, in_view: 1'b0, ok: 1'b0};
    if (img_w == 0 || img_h == 0 || win_w == 0 || win_h == 0) return m;
    r = fit_rect();
    if (q.cmd == CMD_TO_IMAGE) begin
      lx = longint'(q.x) - r.ox;
      ly = longint'(q.y) - r.oy;
      m.in_view = (lx >= 0 && ly >= 0 && lx < r.dw && ly < r.dh);
      rx = clip((lx * img_w) / r.dw, 0, img_w - 1);
      ry = clip((ly * img_h) / r.dh, 0, img_h - 1);
    end else begin
      rx = r.ox + (longint'(q.x) * r.dw) / img_w;
      ry = r.oy + (longint'(q.y) * r.dh) / img_h;
    end
    m.rx = clip(rx, OUT_MIN, OUT_MAX);
    m.ry = clip(ry, OUT_MIN, OUT_MAX);
    m.ok = 1'b1;
    return m;
  endfunction

  // sender: bursty gaps unless calm
  int gap_left = 0;
  always @(posedge clk) begin
    if (rst) begin
      coord_in.valid <= 1'b0;
    end else begin
      if (coord_in.valid && coord_in.ready) begin
        expected_maps.push_back(map_point('{coord_in.command, coord_in.coord_x,
                                            coord_in.coord_y}));
        n_sent++;
      end
      if (coord_in.valid && !coord_in.ready) begin
        // hold the offered item
      end else if (gap_left > 0) begin
        gap_left <= gap_left - 1;
        coord_in.valid <= 1'b0;
      end else if (pending_items.size() > 0 && (calm || $urandom_range(0, 9) != 0)) begin
        coord_req_t q;
        q = pending_items.pop_front();
        coord_in.command <= q.cmd;
        coord_in.coord_x <= q.x;
        coord_in.coord_y <= q.y;
        coord_in.valid   <= 1'b1;
      end else begin
        coord_in.valid <= 1'b0;
        if (pending_items.size() > 0) gap_left <= $urandom_range(1, 15);
      end
    end
  end

  initial begin
    coord_in.valid   = 1'b0;
    coord_in.command = CMD_TO_IMAGE;
    coord_in.coord_x = '0;
    coord_in.coord_y = '0;
    coord_out.ready  = 1'b0;
  end

  // receiver: random stalls plus one long hold-off
  int stall_left = 0;
  int press_left = 0;
  bit press_done = 1'b0;
  always @(posedge clk) begin
    if (rst) begin
      coord_out.ready <= 1'b0;
    end else if (press_req && !press_done) begin
      press_done <= 1'b1;
      press_left <= 300;
      coord_out.ready <= 1'b0;
    end else if (press_left > 0) begin
      press_left <= press_left - 1;
      coord_out.ready <= 1'b0;
    end else if (stall_left > 0) begin
      stall_left <= stall_left - 1;
      coord_out.ready <= 1'b0;
    end else if (!calm && $urandom_range(0, 9) == 0) begin
      stall_left <= $urandom_range(0, 14);
      coord_out.ready <= 1'b0;
    end else begin
      coord_out.ready <= 1'b1;
    end
  end

  always @(posedge clk) begin
    if (!rst && coord_out.valid && coord_out.ready) begin
      if (expected_maps.size() == 0) begin
        $error("result item with nothing expected");
        errors++;
      end else begin
        mapped_t e;
        e = expected_maps.pop_front();
        n_checked++;
        if (coord_out.result_x !== e.rx) begin
          $error("result_x expected %0d actual %0d", e.rx, coord_out.result_x);
          errors++;
        end
        if (coord_out.result_y !== e.ry) begin
          $error("result_y expected %0d actual %0d", e.ry, coord_out.result_y);
          errors++;
        end
        if (coord_out.inside_view !== e.in_view) begin
          $error("inside_view expected %0b actual %0b", e.in_view, coord_out.inside_view);
          errors++;
        end
        if (coord_out.geometry_ok !== e.ok) begin
          $error("geometry_ok expected %0b actual %0b", e.ok, coord_out.geometry_ok);
          errors++;
        end
      end
    end
  end

  task automatic write_regs(longint iw, longint ih, longint ww, longint wh, longint zm,
                            longint ph, longint pv);
    longint vals[7];
    vals = '{iw, ih, ww, wh, zm, ph, pv};
    for (int i = 0; i < 7; i++) begin
      @(posedge clk);
      cfg_we    <= 1'b1;
      cfg_index <= reg_idx_t'(i);
      cfg_data  <= vals[i][CFG_DATA_W-1:0];
    end
    @(posedge clk);
    cfg_we <= 1'b0;
    img_w = iw; img_h = ih; win_w = ww; win_h = wh; zoom = zm;
    pan_h = ph; pan_v = pv;
  endtask

  task automatic add_item(logic cmd, longint x, longint y);
    pending_items.push_back('{cmd, COORD_W'(clip(x, -16384, 16383)),
                              COORD_W'(clip(y, -16384, 16383))});
  endtask

  function automatic longint pick(longint lo, longint hi);
    if (hi - lo > 30000) hi = lo + 30000;
    return lo + longint'($urandom_range(0, int'(hi - lo)));
  endfunction

  task automatic add_random(int count);
    rect_t r;
    logic  cmd;
    r = fit_rect();
    for (int k = 0; k < count; k++) begin
      cmd = $urandom_range(0, 1);
      if ($urandom_range(0, 3) == 0)
        pending_items.push_back('{cmd, COORD_W'($urandom), COORD_W'($urandom)});
      else if (cmd == CMD_TO_IMAGE)
        add_item(cmd, pick(r.ox - 40, r.ox + r.dw + 40), pick(r.oy - 40, r.oy + r.dh + 40));
      else
        add_item(cmd, pick(-20, img_w + 20), pick(-20, img_h + 20));
    end
  endtask

  task automatic drain();
    while (pending_items.size() != 0 || coord_in.valid || expected_maps.size() != 0)
      @(posedge clk);
    repeat (45) @(posedge clk);
  endtask

  initial begin
    rect_t r;
    repeat (7) @(posedge clk);
    rst <= 1'b0;

    // reset values: no geometry
    add_random(20);
    drain();

    write_regs(640, 480, 1920, 1080, ZOOM_ONE, 0, 0);
    r = fit_rect();
    add_item(CMD_TO_IMAGE, -16384, -16384);
    add_item(CMD_TO_IMAGE, 16383, 16383);
    add_item(CMD_TO_SCREEN, -16384, 16383);
    add_item(CMD_TO_SCREEN, 16383, -16384);
    add_item(CMD_TO_IMAGE, 0, 0);
    add_item(CMD_TO_SCREEN, 0, 0);
    add_item(CMD_TO_SCREEN, 639, 479);
    // rectangle edges: just outside, first, last, just past
    add_item(CMD_TO_IMAGE, r.ox - 1, r.oy);
    add_item(CMD_TO_IMAGE, r.ox, r.oy - 1);
    add_item(CMD_TO_IMAGE, r.ox, r.oy);
    add_item(CMD_TO_IMAGE, r.ox + r.dw - 1, r.oy + r.dh - 1);
    add_item(CMD_TO_IMAGE, r.ox + r.dw, r.oy + r.dh - 1);
    add_item(CMD_TO_IMAGE, r.ox + r.dw - 1, r.oy + r.dh);
    add_random(200);
    drain();

    write_regs(1, 1, 8191, 8191, 65535, 8191, -8192);   // huge drawn size, saturation
    add_random(215);
    drain();
    write_regs(8191, 8191, 1, 1, 0, -8192, 8191);       // zoom zero, one-pixel drawn size
    add_random(215);
    drain();
    write_regs(100, 3000, 800, 600, 384, -37, 55);      // height-limited fit
    add_random(215);
    drain();
    write_regs(4000, 50, 1024, 768, 128, 12, -9);       // width-limited fit
    add_random(215);
    drain();
    write_regs(800, 600, 1600, 1200, 1, 0, 0);          // equal ratios, tiny zoom
    add_random(215);
    drain();
    write_regs(0, 480, 640, 480, 300, 5, 5);            // zero image width
    add_random(100);
    drain();

    write_regs(333, 777, 1280, 720, 1000, -500, 300);
    @(posedge clk);
    press_req <= 1'b1;
    add_random(215);
    drain();

    calm = 1'b1;
    write_regs(1920, 1080, 1920, 1080, ZOOM_ONE, 3, -3);
    add_random(215);
    drain();

    if (expected_maps.size() != 0) begin
      $error("%0d expected results never arrived", expected_maps.size());
      errors++;
    end
    $display("Sent %0d coordinate items over 10 register settings, checked %0d results.",
             n_sent, n_checked);
    $display("Covered zero sizes, zoom 0/min/max, pan extremes, both fit axes, long stall.");
    if (errors == 0) begin
      $display("ALL CHECKS PASSED");
    end else begin
      $display("CHECKS FAILED");
    end
    $finish;
  end

  initial begin
    #800000;
    $display("CHECKS FAILED");
    $finish;
  end

endmodule
